// ===== rtl/core/mwcs_pkg.sv =====
`default_nettype none

package mwcs_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned STATE_W       = 2 * WORD_W;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned MAX_TRIES_DEF = 64;

    localparam logic [WORD_W-1:0] BASE_MULT_RESET = 32'd4294967118;
    localparam logic [WORD_W-1:0] WORD_ONES       = '1;

    // input kind carried on s_tuser
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    // result status carried on m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SEED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_SEEDED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MULT   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 3'd4;

    typedef enum logic [7:0] {
        SEQ_IDLE  = 8'b0000_0001,
        SEQ_MUL_A = 8'b0000_0010,
        SEQ_ADD_A = 8'b0000_0100,
        SEQ_MUL_C = 8'b0000_1000,
        SEQ_MUL_B = 8'b0001_0000,
        SEQ_ADD_B = 8'b0010_0000,
        SEQ_CHECK = 8'b0100_0000,
        SEQ_DONE  = 8'b1000_0000
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwc_generator_seeder.sv =====
// Sequencing: a load item, or a generate item refused at once, goes from SEQ_IDLE to
// SEQ_DONE; a generate item runs MUL_A, ADD_A, MUL_C, MUL_B, ADD_B, CHECK for each candidate
// try (1..MAX_TRIES tries), then SEQ_DONE, which waits for a free output register.
// Flow: one item at a time; s_tready returns once the result is in the output register.
// The single 32x32 multiplier is used three times per try.
// Reset: aresetn synchronous, active low; clears the sequencer, seeded flag, master
// state, output valid, and reloads base_multiplier with its reset value.
`default_nettype none

module mwc_generator_seeder
    import mwcs_pkg::*;
#(
    parameter int unsigned MAX_TRIES = MAX_TRIES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration: base_multiplier
    input  wire logic                  cfg_wen,
    input  wire logic [WORD_W-1:0]     cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [95:0]           s_tdata,   // [63:0] seed, [95:64] multiplier
    input  wire logic                  s_tuser,   // [0] command
    input  wire logic                  s_tlast,   // last_generator
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [95:0]                m_tdata,   // [63:0] lane_word, [95:64] multiplier_out
    output logic [STATUS_W-1:0]        m_tuser,   // [2:0] status
    output logic                       m_tlast    // last_out
);

    localparam int unsigned TRIES_W = $clog2(MAX_TRIES + 1);
    localparam logic [TRIES_W-1:0] TRIES_LAST = TRIES_W'(MAX_TRIES - 1);

    seq_state_t            state_reg, state_next;
    logic [WORD_W-1:0]     base_reg, base_next;
    logic [STATE_W-1:0]    master_reg, master_next;
    logic                  seeded_reg, seeded_next;
    logic [STATE_W-1:0]    prod_reg, prod_next;
    logic [WORD_W-1:0]     carry_reg, carry_next;
    logic [TRIES_W-1:0]    tries_reg, tries_next;
    logic [WORD_W-1:0]     mult_reg, mult_next;
    logic                  last_reg, last_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [STATE_W-1:0]    res_word_reg, res_word_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [STATE_W-1:0]    m_word_reg, m_word_next;
    logic [WORD_W-1:0]     m_mult_reg, m_mult_next;
    logic                  m_last_reg, m_last_next;

    logic                  in_beat;
    logic [STATE_W-1:0]    in_seed;
    logic [WORD_W-1:0]     in_mult;
    logic                  seed_bad;
    logic [WORD_W-1:0]     mul_b;
    logic [STATE_W-1:0]    mul_p;
    logic [STATE_W-1:0]    step_sum;
    logic [WORD_W-1:0]     cand_v;
    logic                  cand_ok;

    assign s_tready = (state_reg == SEQ_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_seed  = s_tdata[63:0];
    assign in_mult  = s_tdata[95:64];

    // reject zero seed, carry at or above base-1 (wrapping), all-ones value word
    assign seed_bad = (in_seed == '0)
                   || (in_seed[63:32] >= (base_reg - WORD_W'(1)))
                   || (in_seed[31:0] == WORD_ONES);

    // shared multiplier: master low word times base, or times the lane multiplier
    assign mul_b    = (state_reg == SEQ_MUL_C) ? mult_reg : base_reg;
    assign mul_p    = STATE_W'(master_reg[31:0]) * STATE_W'(mul_b);
    // master step completes as product plus old carry
    assign step_sum = prod_reg + {{WORD_W{1'b0}}, master_reg[63:32]};

    assign cand_v  = master_reg[31:0];
    assign cand_ok = !((carry_reg == '0) && (cand_v == '0))
                  && (carry_reg < (mult_reg - WORD_W'(1)))
                  && (cand_v != WORD_ONES);

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        master_next     = master_reg;
        seeded_next     = seeded_reg;
        prod_next       = prod_reg;
        carry_next      = carry_reg;
        tries_next      = tries_reg;
        mult_next       = mult_reg;
        last_next       = last_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_word_next     = m_word_reg;
        m_mult_next     = m_mult_reg;
        m_last_next     = m_last_reg;

        // configuration is to be written only while idle; the block itself does not enforce it
        if (cfg_wen) begin
            base_next = cfg_wdata;
        end

        // drop the output beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE: begin
                if (in_beat) begin
                    mult_next     = in_mult;
                    last_next     = s_tlast;
                    res_word_next = '0;
                    tries_next    = '0;
                    if (s_tuser == CMD_LOAD) begin
                        state_next = SEQ_DONE;
                        if (seed_bad) begin
                            res_status_next = STATUS_BAD_SEED;
                            seeded_next     = 1'b0;
                        end else begin
                            res_status_next = STATUS_OK;
                            master_next     = in_seed;
                            seeded_next     = 1'b1;
                        end
                    end else if (!seeded_reg) begin
                        res_status_next = STATUS_NOT_SEEDED;
                        state_next      = SEQ_DONE;
                    end else if (in_mult < WORD_W'(2)) begin
                        res_status_next = STATUS_BAD_MULT;
                        state_next      = SEQ_DONE;
                    end else begin
                        state_next = SEQ_MUL_A;
                    end
                end
            end
            SEQ_MUL_A: begin
                prod_next  = mul_p;
                state_next = SEQ_ADD_A;
            end
            SEQ_ADD_A: begin
                master_next = step_sum;
                state_next  = SEQ_MUL_C;
            end
            SEQ_MUL_C: begin
                prod_next  = mul_p;
                state_next = SEQ_MUL_B;
            end
            SEQ_MUL_B: begin
                carry_next = prod_reg[63:32];
                prod_next  = mul_p;
                state_next = SEQ_ADD_B;
            end
            SEQ_ADD_B: begin
                master_next = step_sum;
                state_next  = SEQ_CHECK;
            end
            SEQ_CHECK: begin
                if (cand_ok) begin
                    res_status_next = STATUS_OK;
                    res_word_next   = {carry_reg, cand_v};
                    state_next      = SEQ_DONE;
                end else if (tries_reg == TRIES_LAST) begin
                    // master keeps its advanced state
                    res_status_next = STATUS_EXHAUSTED;
                    state_next      = SEQ_DONE;
                end else begin
                    tries_next = tries_reg + TRIES_W'(1);
                    state_next = SEQ_MUL_A;
                end
            end
            SEQ_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_word_next   = res_word_reg;
                    m_mult_next   = mult_reg;
                    m_last_next   = last_reg;
                    state_next    = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            base_reg    <= BASE_MULT_RESET;
            master_reg  <= '0;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            master_reg  <= master_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        carry_reg      <= carry_next;
        tries_reg      <= tries_next;
        mult_reg       <= mult_next;
        last_reg       <= last_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        m_status_reg   <= m_status_next;
        m_word_reg     <= m_word_next;
        m_mult_reg     <= m_mult_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_mult_reg, m_word_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mwcs_checker.sv =====
`default_nettype none

module mwcs_checker
    import mwcs_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [95:0]         m_tdata,
    input wire logic [STATUS_W-1:0] m_tuser
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops after an accepted beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // any status other than ok carries a zero lane word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[63:0] == '0))
        else $error("nonzero lane word with failing status");

    // a delivered lane word keeps its carry below multiplier minus one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OK) && (m_tdata[63:0] != '0)
        |-> (m_tdata[63:32] < (m_tdata[95:64] - 32'd1)))
        else $error("lane carry out of range");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mwc_generator_seeder mwcs_checker u_mwcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
